[hdl/tsct_pkg.sv]
package tsct_pkg;

    // Keycodes (HID usage)
    localparam logic [15:0] KC_A    = 16'h0004;
    localparam logic [15:0] KC_Z    = 16'h001D;
    localparam logic [15:0] KC_SCLN = 16'h0033;
    localparam logic [15:0] KC_COMM = 16'h0036;
    localparam logic [15:0] KC_DOT  = 16'h0037;
    localparam logic [15:0] KC_SLSH = 16'h0038;
    localparam logic [15:0] KC_LCTL = 16'h00E0;
    localparam logic [15:0] KC_RGUI = 16'h00E7;

    // Modifier counter saturation
    localparam logic [3:0] MOD_MAX = 4'd15;

    // Result kinds
    localparam logic [1:0] KIND_VERDICT = 2'd0;
    localparam logic [1:0] KIND_CHAR    = 2'd1;
    localparam logic [1:0] KIND_TAP     = 2'd2;

    // Chord table columns
    localparam logic [1:0] COL_ALONE = 2'd0;
    localparam logic [1:0] COL_LEFT  = 2'd1;
    localparam logic [1:0] COL_RIGHT = 2'd2;

    // Configuration register indexes
    localparam logic [7:0] CFG_LEFT_THUMB  = 8'd0;
    localparam logic [7:0] CFG_RIGHT_THUMB = 8'd1;

    localparam logic [7:0] NUL = 8'h00;

    typedef struct packed {
        logic [15:0] key_code;
        logic        is_press;
        logic        layer_active;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
        logic        last;
    } t_out_beat;

    // What one event asks the emitter to send
    typedef struct packed {
        logic        emit_chord;
        logic        emit_tap;
        logic [1:0]  col;
        logic [1:0]  key_cnt;
        logic [7:0]  key0;
        logic [7:0]  key1;
        logic [15:0] tap_code;
        logic        verdict;
    } t_plan;

    // {hit, row}: row of the chord table for a keycode
    function automatic logic [5:0] rom_row(input logic [15:0] code);
        logic [15:0] diff;
        diff = code - KC_A;
        if (code >= KC_A && code <= KC_Z) begin
            rom_row = {1'b1, diff[4:0]};
        end else if (code == KC_SCLN) begin
            rom_row = {1'b1, 5'd26};
        end else if (code == KC_COMM) begin
            rom_row = {1'b1, 5'd27};
        end else if (code == KC_DOT) begin
            rom_row = {1'b1, 5'd28};
        end else if (code == KC_SLSH) begin
            rom_row = {1'b1, 5'd29};
        end else begin
            rom_row = 6'd0;
        end
    endfunction

    // One row: alone, left, right; three chars each, first char highest
    function automatic logic [71:0] rom_entry(input logic [4:0] row);
        case (row)
            5'd0:  rom_entry = {"u", NUL, NUL, "w", "o", NUL, "v", "u", NUL};
            5'd1:  rom_entry = {"h", "e", NUL, "l", "i", NUL, "b", "e", NUL};
            5'd2:  rom_entry = {"s", "u", NUL, "r", "o", NUL, "z", "u", NUL};
            5'd3:  rom_entry = {"t", "e", NUL, "n", "a", NUL, "d", "e", NUL};
            5'd4:  rom_entry = {"t", "a", NUL, "r", "i", NUL, "d", "a", NUL};
            5'd5:  rom_entry = {"k", "e", NUL, "l", "y", "u", "g", "e", NUL};
            5'd6:  rom_entry = {"s", "e", NUL, "m", "o", NUL, "z", "e", NUL};
            5'd7:  rom_entry = {"h", "a", NUL, "b", "a", NUL, "m", "i", NUL};
            5'd8:  rom_entry = {"k", "u", NUL, "g", "u", NUL, "r", "u", NUL};
            5'd9:  rom_entry = {"t", "o", NUL, "d", "o", NUL, "o", NUL, NUL};
            5'd10: rom_entry = {"k", "i", NUL, "g", "i", NUL, "n", "o", NUL};
            5'd11: rom_entry = {"i", NUL, NUL, "p", "o", NUL, "l", "y", "o"};
            5'd12: rom_entry = {"s", "o", NUL, "z", "o", NUL, "y", "u", NUL};
            5'd13: rom_entry = {"m", "e", NUL, "p", "u", NUL, "n", "u", NUL};
            5'd14: rom_entry = {"t", "u", NUL, "d", "u", NUL, "m", "a", NUL};
            5'd15: rom_entry = {",", NUL, NUL, "p", "i", NUL, "l", "e", NUL};
            5'd16: rom_entry = {".", NUL, NUL, "l", "a", NUL, NUL, NUL, NUL};
            5'd17: rom_entry = {"k", "o", NUL, "l", "y", "a", "g", "o", NUL};
            5'd18: rom_entry = {"s", "i", NUL, "a", NUL, NUL, "z", "i", NUL};
            5'd19: rom_entry = {"s", "a", NUL, "r", "e", NUL, "z", "a", NUL};
            5'd20: rom_entry = {"t", "i", NUL, "d", "i", NUL, "n", "i", NUL};
            5'd21: rom_entry = {"h", "u", NUL, "y", "a", NUL, "b", "u", NUL};
            5'd22: rom_entry = {"k", "a", NUL, "e", NUL, NUL, "g", "a", NUL};
            5'd23: rom_entry = {"h", "i", NUL, "-", NUL, NUL, "b", "i", NUL};
            5'd24: rom_entry = {"r", "a", NUL, "p", "a", NUL, "y", "o", NUL};
            5'd25: rom_entry = {".", NUL, NUL, "l", "u", NUL, NUL, NUL, NUL};
            5'd26: rom_entry = {"n", "n", NUL, NUL, NUL, NUL, "l", "t", "u"};
            5'd27: rom_entry = {"n", "e", NUL, "p", "e", NUL, "m", "u", NUL};
            5'd28: rom_entry = {"h", "o", NUL, "b", "o", NUL, "w", "a", NUL};
            5'd29: rom_entry = {"/", NUL, NUL, "?", NUL, NUL, "l", "o", NUL};
            default: rom_entry = 72'd0;
        endcase
    endfunction

endpackage

[hdl/thumb_shift_chord_translator_core.sv]
// An accepted event is registered, decided in the EVAL state and sent from the EMIT
// state through the output register; the verdict beat always closes the event.
// One event at a time: after the decision come an optional tap beat, then one table
// lookup per cycle while the output is free (up to 3 per key), then the verdict.
// Reset (synchronous, active low): counters, held flags and thumb keycodes go to 0;
// buffered keycodes are left as they are.
module thumb_shift_chord_translator_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tsct_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tsct_pkg::t_out_beat o_out_beat
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]          r_state, n_state;
    tsct_pkg::t_in_beat  r_beat;
    tsct_pkg::t_plan     r_plan, n_plan;
    logic [1:0]          r_key_pos, n_key_pos;
    logic [1:0]          r_chr_idx, n_chr_idx;
    logic                r_out_valid;
    tsct_pkg::t_out_beat r_out, n_out;
    logic [15:0]         r_left_key;
    logic [15:0]         r_right_key;

    tsct_pkg::t_plan eval_plan;
    logic            eval_strobe;
    logic            in_accept;
    logic            out_free;
    logic            out_load;
    logic [7:0]      cur_key;
    logic [7:0]      rom_char;
    logic            rom_hit;

    // Config port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_key  <= 16'd0;
            r_right_key <= 16'd0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == tsct_pkg::CFG_LEFT_THUMB) begin
                r_left_key <= i_cfg_data;
            end
            if (i_cfg_index == tsct_pkg::CFG_RIGHT_THUMB) begin
                r_right_key <= i_cfg_data;
            end
        end
    end

    // Input handshake
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_beat <= i_in_beat;
        end
    end

    // Event decision and chord state
    tsct_event_eval u_eval (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_eval      (eval_strobe),
        .i_beat      (r_beat),
        .i_left_key  (r_left_key),
        .i_right_key (r_right_key),
        .o_plan      (eval_plan)
    );

    // Shared character lookup
    assign cur_key = r_key_pos[0] ? r_plan.key1 : r_plan.key0;

    tsct_chord_rom u_rom (
        .i_key  (cur_key),
        .i_col  (r_plan.col),
        .i_idx  (r_chr_idx),
        .o_char (rom_char),
        .o_hit  (rom_hit)
    );

    // Output register frees when empty or taken this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_plan      = r_plan;
        n_key_pos   = r_key_pos;
        n_chr_idx   = r_chr_idx;
        n_out       = r_out;
        out_load    = 1'b0;
        eval_strobe = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                eval_strobe = 1'b1;
                n_plan      = eval_plan;
                n_key_pos   = 2'd0;
                n_chr_idx   = 2'd0;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (r_plan.emit_tap) begin
                        out_load        = 1'b1;
                        n_out.kind      = tsct_pkg::KIND_TAP;
                        n_out.value     = r_plan.tap_code;
                        n_out.last      = 1'b0;
                        n_plan.emit_tap = 1'b0;
                    end else if (r_plan.emit_chord && (r_key_pos != r_plan.key_cnt)) begin
                        if (rom_hit) begin
                            out_load    = 1'b1;
                            n_out.kind  = tsct_pkg::KIND_CHAR;
                            n_out.value = {8'h00, rom_char};
                            n_out.last  = 1'b0;
                        end
                        // next key on end of string or after the third char
                        if (!rom_hit || (r_chr_idx == 2'd2)) begin
                            n_key_pos = r_key_pos + 2'd1;
                            n_chr_idx = 2'd0;
                        end else begin
                            n_chr_idx = r_chr_idx + 2'd1;
                        end
                    end else begin
                        out_load    = 1'b1;
                        n_out.kind  = tsct_pkg::KIND_VERDICT;
                        n_out.value = {15'd0, r_plan.verdict};
                        n_out.last  = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_plan    <= n_plan;
        r_key_pos <= n_key_pos;
        r_chr_idx <= n_chr_idx;
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

[hdl/tsct_chord_rom.sv]
module tsct_chord_rom (
    input  logic [7:0] i_key,
    input  logic [1:0] i_col,
    input  logic [1:0] i_idx,
    output logic [7:0] o_char,
    output logic       o_hit
);

    logic [5:0]  row_info;
    logic [71:0] entry;
    logic [23:0] cell_chars;

    // Row lookup and table read
    assign row_info = tsct_pkg::rom_row({8'h00, i_key});
    assign entry    = tsct_pkg::rom_entry(row_info[4:0]);

    // Column select
    always_comb begin
        unique case (i_col)
            tsct_pkg::COL_ALONE: cell_chars = entry[71:48];
            tsct_pkg::COL_LEFT:  cell_chars = entry[47:24];
            tsct_pkg::COL_RIGHT: cell_chars = entry[23:0];
            default:             cell_chars = 24'd0;
        endcase
    end

    // Character select; a zero byte ends the string
    always_comb begin
        case (i_idx)
            2'd0:    o_char = cell_chars[23:16];
            2'd1:    o_char = cell_chars[15:8];
            2'd2:    o_char = cell_chars[7:0];
            default: o_char = 8'h00;
        endcase
    end

    assign o_hit = row_info[5] && (o_char != 8'h00);

endmodule

[hdl/tsct_event_eval.sv]
module tsct_event_eval (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_eval,
    input  tsct_pkg::t_in_beat i_beat,
    input  logic [15:0]        i_left_key,
    input  logic [15:0]        i_right_key,
    output tsct_pkg::t_plan    o_plan
);

    // Chord and modifier state
    logic [7:0] r_key0, n_key0;
    logic [7:0] r_key1, n_key1;
    logic [1:0] r_pend_cnt, n_pend_cnt;
    logic [1:0] r_chord_cnt, n_chord_cnt;
    logic [3:0] r_mod_cnt, n_mod_cnt;
    logic       r_left_held, n_left_held;
    logic       r_right_held, n_right_held;
    logic       r_mod_seen, n_mod_seen;

    logic       is_mod;
    logic       is_left;
    logic       is_right;
    logic [5:0] row_info;
    logic [1:0] chord_inc;
    logic       do_emit;
    logic       do_clear;

    assign is_mod    = (i_beat.key_code >= tsct_pkg::KC_LCTL) &&
                       (i_beat.key_code <= tsct_pkg::KC_RGUI);
    assign is_left   = (i_beat.key_code == i_left_key);
    assign is_right  = !is_left && (i_beat.key_code == i_right_key);
    assign row_info  = tsct_pkg::rom_row(i_beat.key_code);
    assign chord_inc = r_chord_cnt + 2'd1;

    // Event decision and next state
    always_comb begin
        n_key0       = r_key0;
        n_key1       = r_key1;
        n_pend_cnt   = r_pend_cnt;
        n_chord_cnt  = r_chord_cnt;
        n_mod_cnt    = r_mod_cnt;
        n_left_held  = r_left_held;
        n_right_held = r_right_held;
        n_mod_seen   = r_mod_seen;
        do_emit      = 1'b0;
        do_clear     = 1'b0;

        o_plan            = '0;
        o_plan.verdict    = 1'b1;
        o_plan.tap_code   = i_beat.key_code;
        o_plan.key0       = r_key0;
        o_plan.key1       = r_key1;
        o_plan.col        = tsct_pkg::COL_ALONE;

        if (is_mod) begin
            if (i_beat.is_press) begin
                if (r_mod_cnt < tsct_pkg::MOD_MAX) begin
                    n_mod_cnt = r_mod_cnt + 4'd1;
                end
                n_mod_seen = 1'b1;
            end else if (r_mod_cnt != 4'd0) begin
                n_mod_cnt = r_mod_cnt - 4'd1;
            end
        end else if (r_mod_cnt != 4'd0) begin
            do_clear = i_beat.is_press;
        end else if (r_mod_seen) begin
            n_mod_seen = 1'b0;
            do_clear   = 1'b1;
        end else if (i_beat.layer_active) begin
            if (i_beat.is_press) begin
                if (is_left || is_right) begin
                    if (is_left) begin
                        n_left_held = 1'b1;
                    end else begin
                        n_right_held = 1'b1;
                    end
                    n_chord_cnt    = chord_inc;
                    do_emit        = (chord_inc > 2'd1);
                    o_plan.verdict = 1'b0;
                end else if (row_info[5]) begin
                    if (r_pend_cnt < 2'd2) begin
                        if (r_pend_cnt == 2'd0) begin
                            n_key0 = i_beat.key_code[7:0];
                        end else begin
                            n_key1 = i_beat.key_code[7:0];
                        end
                        n_pend_cnt = r_pend_cnt + 2'd1;
                    end
                    n_chord_cnt    = chord_inc;
                    do_emit        = (chord_inc > 2'd1);
                    o_plan.verdict = 1'b0;
                end else begin
                    do_clear = 1'b1;
                end
            end else begin
                if (is_left || is_right) begin
                    if (is_left) begin
                        n_left_held = 1'b0;
                    end else begin
                        n_right_held = 1'b0;
                    end
                    if (r_chord_cnt != 2'd0) begin
                        if (r_chord_cnt == 2'd1 && r_pend_cnt == 2'd0) begin
                            // thumb key alone: tap
                            o_plan.emit_tap = 1'b1;
                            do_clear        = 1'b1;
                        end else begin
                            do_emit = 1'b1;
                        end
                    end
                    o_plan.verdict = 1'b0;
                end else if (row_info[5]) begin
                    do_emit        = (r_chord_cnt != 2'd0);
                    o_plan.verdict = 1'b0;
                end
            end
        end

        // Chord snapshot uses the updated buffer and thumb state
        if (do_emit) begin
            o_plan.emit_chord = 1'b1;
            o_plan.key0       = n_key0;
            o_plan.key1       = n_key1;
            o_plan.key_cnt    = n_pend_cnt;
            if (n_left_held) begin
                o_plan.col = tsct_pkg::COL_LEFT;
            end else if (n_right_held) begin
                o_plan.col = tsct_pkg::COL_RIGHT;
            end
            do_clear = 1'b1;
        end

        if (do_clear) begin
            n_pend_cnt   = 2'd0;
            n_chord_cnt  = 2'd0;
            n_left_held  = 1'b0;
            n_right_held = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt   <= 2'd0;
            r_chord_cnt  <= 2'd0;
            r_mod_cnt    <= 4'd0;
            r_left_held  <= 1'b0;
            r_right_held <= 1'b0;
            r_mod_seen   <= 1'b0;
        end else if (i_eval) begin
            r_pend_cnt   <= n_pend_cnt;
            r_chord_cnt  <= n_chord_cnt;
            r_mod_cnt    <= n_mod_cnt;
            r_left_held  <= n_left_held;
            r_right_held <= n_right_held;
            r_mod_seen   <= n_mod_seen;
        end
    end

    // Buffered chord keycodes, read only once written
    always_ff @(posedge i_clk) begin
        if (i_eval) begin
            r_key0 <= n_key0;
            r_key1 <= n_key1;
        end
    end

endmodule
